// ===== hdl/plc_pkg.sv =====
package plc_pkg;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV,
		S_MUL_I,
		S_WR,
		S_RD,
		S_CHK,
		S_MUL_E,
		S_ADD_E,
		S_FIN
	} state_t;

	localparam logic [1:0] REQ_CLEAR  = 2'd0;
	localparam logic [1:0] REQ_APPEND = 2'd1;
	localparam logic [1:0] REQ_EVAL   = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_ZERO  = 2'd2;
	localparam logic [1:0] STAT_FULL  = 2'd3;

	localparam int DIVIDEND_W = 49;
	localparam int DIVISOR_W  = 33;

	// clamp a 49-bit signed value to 32 bits
	function automatic logic signed [31:0] sat49(input logic signed [48:0] v);
		logic signed [31:0] r;
		if (v > 49'sh0_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -49'sh0_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ===== hdl/plc_ram.sv =====
module plc_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 63
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/plc_div.sv =====
module plc_div (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [plc_pkg::DIVIDEND_W-1:0]        dividend,
	input  logic [plc_pkg::DIVISOR_W-1:0]         divisor,
	output logic                                  done,
	output logic [plc_pkg::DIVIDEND_W-1:0]        quotient
);

	logic [5:0]                            cnt_q;
	logic                                  done_q;
	logic [plc_pkg::DIVISOR_W:0]           rem_q;
	logic [plc_pkg::DIVIDEND_W-1:0]        quo_q;
	logic [plc_pkg::DIVISOR_W-1:0]         dvs_q;
	logic [plc_pkg::DIVISOR_W:0]           trial;
	logic                                  fits;

	// shift in one dividend bit, subtract when the divisor fits
	assign trial = {rem_q[plc_pkg::DIVISOR_W-1:0], quo_q[plc_pkg::DIVIDEND_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= 6'(plc_pkg::DIVIDEND_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? trial - {1'b0, dvs_q} : trial;
			quo_q <= {quo_q[plc_pkg::DIVIDEND_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== hdl/piecewise_linear_calibration_top.sv =====
// Piecewise linear sensor calibration.
// Command channel: a word (req_type, point_x, point_y, sample) is taken at a
// rising edge with start high and busy low. busy stays high until the result
// word has been shown. Request codes: clear table, append point, evaluate.
// Result channel: value and status sit on the ports for one cycle with done
// high; the receiver cannot stall it, so nothing waits on the far side.
// Work done for each request before its result word is shown:
//   clear, unused code, first point, full table, empty evaluate: result only.
//   append with equal x (zero-width segment): one multiply and
//   one table write.
//   append that forms a segment: the 49-step restoring divider produces
//   the slope, then one multiply and one table write.
//   evaluate: k segments examined (1..MAX_POINTS-1); each
//   examined segment costs a registered table read plus a compare.
// done is high in the final state before the block returns to idle.
// One item is in work at a time, so a new word waits until the last result is shown.
// Reset empties the table (point count, previous point, direction); the
// segment memory itself is not cleared, as only written entries are read.
module piecewise_linear_calibration_top #(
	parameter int MAX_POINTS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         req_type,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] sample,
	output logic               done,
	output logic signed [31:0] value,
	output logic [1:0]         status
);

	localparam int NSEG = MAX_POINTS - 1;
	localparam int AW   = NSEG > 1 ? $clog2(NSEG) : 1;
	localparam int CW   = $clog2(MAX_POINTS + 1);

	plc_pkg::state_t state_q, state_d;

	logic [CW-1:0]      cnt_q;
	logic signed [31:0] px_q, py_q, x_q, y_q, s_q;
	logic               desc_q;
	logic [AW-1:0]      idx_q;
	logic signed [31:0] slope_q, icpt_q, val_q;
	logic [1:0]         st_q;
	logic signed [63:0] p_q;
	logic               neg_q;

	// accept-time decode
	logic               accept;
	logic signed [32:0] dx, dy;
	logic [32:0]        adx, ady;
	logic               seg_app, div_go;
	logic [CW-1:0]      nseg;
	logic               last, hit;

	logic               div_done;
	logic [48:0]        quo;
	logic signed [31:0] slope_sat;

	logic               ram_we;
	logic [AW-1:0]      ram_raddr, ram_waddr;
	logic [95:0]        ram_wdata, ram_rdata;
	logic signed [31:0] rd_bp, rd_slope, rd_icpt;

	logic signed [31:0] mul_b;
	logic signed [48:0] p_sh;
	logic signed [31:0] icpt_wr;

	assign accept  = start && !busy;
	assign dx      = 33'(point_x) - 33'(px_q);
	assign dy      = 33'(point_y) - 33'(py_q);
	assign adx     = dx[32] ? 33'(-dx) : 33'(dx);
	assign ady     = dy[32] ? 33'(-dy) : 33'(dy);
	assign seg_app = (cnt_q != '0) && (cnt_q < CW'(MAX_POINTS));
	assign div_go  = accept && req_type == plc_pkg::REQ_APPEND && seg_app && dx != '0;
	assign nseg    = cnt_q - CW'(1);

	assign rd_bp    = ram_rdata[95:64];
	assign rd_slope = ram_rdata[63:32];
	assign rd_icpt  = ram_rdata[31:0];
	assign hit      = s_q < rd_bp;
	assign last     = desc_q ? (idx_q == '0) : (CW'(idx_q) == nseg - CW'(1));

	// magnitude quotient back to signed, clamped to 32 bits
	always_comb begin
		if (quo >= 49'h0_8000_0000) begin
			slope_sat = neg_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			slope_sat = neg_q ? 32'(-$signed({1'b0, quo[31:0]})) : $signed(quo[31:0]);
		end
	end

	plc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go),
		.dividend ({ady, 16'h0000}),
		.divisor  (adx),
		.done     (div_done),
		.quotient (quo)
	);

	plc_ram #(.WIDTH(96), .DEPTH(NSEG)) u_seg (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			plc_pkg::S_IDLE: begin
				if (accept) begin
					if (div_go) begin
						state_d = plc_pkg::S_DIV;
					end else if (req_type == plc_pkg::REQ_APPEND && seg_app) begin
						state_d = plc_pkg::S_MUL_I;
					end else if (req_type == plc_pkg::REQ_EVAL && cnt_q >= CW'(2)) begin
						state_d = plc_pkg::S_RD;
					end else begin
						state_d = plc_pkg::S_FIN;
					end
				end
			end
			plc_pkg::S_DIV:   if (div_done) state_d = plc_pkg::S_MUL_I;
			plc_pkg::S_MUL_I: state_d = plc_pkg::S_WR;
			plc_pkg::S_WR:    state_d = plc_pkg::S_FIN;
			plc_pkg::S_RD:    state_d = plc_pkg::S_CHK;
			plc_pkg::S_CHK:   state_d = (hit || last) ? plc_pkg::S_MUL_E : plc_pkg::S_RD;
			plc_pkg::S_MUL_E: state_d = plc_pkg::S_ADD_E;
			plc_pkg::S_ADD_E: state_d = plc_pkg::S_FIN;
			plc_pkg::S_FIN:   state_d = plc_pkg::S_IDLE;
			default:          state_d = plc_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy      = state_q != plc_pkg::S_IDLE;
		done      = state_q == plc_pkg::S_FIN;
		ram_we    = state_q == plc_pkg::S_WR;
		ram_raddr = idx_q;
		ram_waddr = AW'(nseg);
		ram_wdata = {desc_q ? px_q : x_q, slope_q, icpt_wr};
	end

	assign value  = val_q;
	assign status = st_q;

	// shared multiplier operand: previous x for intercept, sample for evaluate
	assign mul_b = (state_q == plc_pkg::S_MUL_I) ? px_q : s_q;
	// floor of the product over 2^16: arithmetic shift keeps the sign
	assign p_sh  = 49'($signed(p_q[63:16]));
	// intercept of the new segment, written in the same cycle it is formed
	assign icpt_wr = plc_pkg::sat49(49'(py_q) - p_sh);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= plc_pkg::S_IDLE;
			cnt_q   <= '0;
			px_q    <= '0;
			py_q    <= '0;
			desc_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == plc_pkg::S_IDLE && accept) begin
				if (req_type == plc_pkg::REQ_CLEAR) begin
					cnt_q  <= '0;
					px_q   <= '0;
					py_q   <= '0;
					desc_q <= 1'b0;
				end else if (req_type == plc_pkg::REQ_APPEND) begin
					if (cnt_q == CW'(1)) begin
						desc_q <= px_q > point_x;
					end
					// first point: just remember it
					if (cnt_q == '0) begin
						px_q  <= point_x;
						py_q  <= point_y;
						cnt_q <= CW'(1);
					end
				end
			end
			if (state_q == plc_pkg::S_WR) begin
				px_q  <= x_q;
				py_q  <= y_q;
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			plc_pkg::S_IDLE: begin
				x_q   <= point_x;
				y_q   <= point_y;
				s_q   <= sample;
				neg_q <= dx[32] ^ dy[32];
				val_q <= '0;
				slope_q <= '0;
				st_q  <= plc_pkg::STAT_OK;
				if (req_type == plc_pkg::REQ_APPEND) begin
					if (!seg_app && cnt_q != '0) begin
						st_q <= plc_pkg::STAT_FULL;
					end else if (seg_app && dx == '0) begin
						st_q <= plc_pkg::STAT_ZERO;
					end
				end else if (req_type == plc_pkg::REQ_EVAL && cnt_q < CW'(2)) begin
					st_q <= plc_pkg::STAT_EMPTY;
				end
				// ascending tables scan up from 0, descending down from the last
				idx_q <= desc_q ? AW'(nseg - CW'(1)) : '0;
			end
			plc_pkg::S_DIV: begin
				if (div_done) begin
					slope_q <= slope_sat;
				end
			end
			plc_pkg::S_MUL_I, plc_pkg::S_MUL_E: begin
				p_q <= slope_q * mul_b;
			end
			plc_pkg::S_WR: begin
			end
			plc_pkg::S_RD: begin
			end
			plc_pkg::S_CHK: begin
				if (hit || last) begin
					slope_q <= rd_slope;
					icpt_q  <= rd_icpt;
				end else begin
					idx_q <= desc_q ? idx_q - AW'(1) : idx_q + AW'(1);
				end
			end
			plc_pkg::S_ADD_E: begin
				val_q <= plc_pkg::sat49(p_sh + 49'(icpt_q));
			end
			plc_pkg::S_FIN: begin
			end
			default: begin
			end
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("result strobe outside a busy window");
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("accepted word did not raise busy");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CW'(MAX_POINTS))
		else $error("point count past capacity");
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == plc_pkg::STAT_FULL) |-> value == '0)
		else $error("full-table append produced a value");

endmodule

// ===== tb/tb_piecewise_linear_calibration_top.sv =====
module tb_piecewise_linear_calibration_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_PTS = 64;
	localparam int NSEG = MAX_PTS - 1;
	localparam logic [1:0] REQ_SPARE = 2'd3;

	typedef struct {
		logic signed [31:0] value;
		logic [1:0]         status;
	} calib_word_t;

	// Scoreboard: own copy of the calibration table plus a queue of expected words.
	class calib_scoreboard;
		logic signed [31:0] brk[NSEG];
		logic signed [31:0] slp[NSEG];
		logic signed [31:0] icp[NSEG];
		int                 npts;
		logic signed [31:0] last_x, last_y;
		bit                 desc;
		calib_word_t        pending[$];
		int                 errors;

		function new();
			npts = 0; last_x = 0; last_y = 0; desc = 0; errors = 0;
		endfunction

		function automatic longint floor_q16(longint v);
			if (v >= 0) return v / 65536;
			return -((-v + 65535) / 65536);
		endfunction

		function automatic logic signed [31:0] clamp32(longint v);
			if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
			if (v < -64'sd2147483648) return 32'sh8000_0000;
			return v[31:0];
		endfunction

		// Update the table for one accepted command word and queue its result.
		function void note_request(logic [1:0] rq, logic signed [31:0] x,
				logic signed [31:0] y, logic signed [31:0] s);
			calib_word_t w;
			longint dx, dy, sl, r;
			int n, idx;
			w.value = 0;
			w.status = plc_pkg::STAT_OK;
			if (rq == plc_pkg::REQ_CLEAR) begin
				npts = 0; last_x = 0; last_y = 0; desc = 0;
			end else if (rq == plc_pkg::REQ_APPEND) begin
				if (npts >= MAX_PTS) begin
					w.status = plc_pkg::STAT_FULL;
				end else begin
					if (npts >= 1) begin
						if (npts == 1) desc = (last_x > x);
						dx = longint'(x) - longint'(last_x);
						dy = longint'(y) - longint'(last_y);
						if (dx == 0) begin
							sl = 0;
							w.status = plc_pkg::STAT_ZERO;
						end else begin
							sl = clamp32((dy * 65536) / dx);
						end
						brk[npts-1] = desc ? last_x : x;
						slp[npts-1] = sl[31:0];
						icp[npts-1] = clamp32(longint'(last_y) - floor_q16(sl * longint'(last_x)));
					end
					last_x = x;
					last_y = y;
					npts++;
				end
			end else if (rq == plc_pkg::REQ_EVAL) begin
				n = (npts > 0) ? npts - 1 : 0;
				if (n > NSEG) n = NSEG;
				if (n == 0) begin
					w.status = plc_pkg::STAT_EMPTY;
				end else begin
					if (n == 1) begin
						idx = 0;
					end else if (!desc) begin
						idx = n - 1;
						for (int i = 0; i < n; i++)
							if (s < brk[i]) begin idx = i; break; end
					end else begin
						idx = 0;
						for (int i = n; i > 0; i--)
							if (s < brk[i-1]) begin idx = i - 1; break; end
					end
					r = floor_q16(longint'(slp[idx]) * longint'(s)) + longint'(icp[idx]);
					w.value = clamp32(r);
				end
			end
			pending.push_back(w);
		endfunction

		function void check_result(logic signed [31:0] v, logic [1:0] st);
			calib_word_t w;
			if (pending.size() == 0) begin
				$error("result word with nothing expected: value=%0d status=%0d", v, st);
				errors++;
				return;
			end
			w = pending.pop_front();
			if (v !== w.value) begin
				$error("value: expected %0d, actual %0d", w.value, v);
				errors++;
			end
			if (st !== w.status) begin
				$error("status: expected %0d, actual %0d", w.status, st);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         req_type;
	logic signed [31:0] point_x, point_y, sample;
	logic               done;
	logic signed [31:0] value;
	logic [1:0]         status;

	calib_scoreboard sb;
	bit              calm;	// set during the stretch with no idle gaps
	int              n_sent;	// accepted command words so far

	piecewise_linear_calibration_top #(.MAX_POINTS(MAX_PTS)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .point_x(point_x), .point_y(point_y), .sample(sample),
		.done(done), .value(value), .status(status)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// Check every result word on the edge that ends its strobe cycle.
	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(value, status);
	end

	// Present one command word; hold start until the block takes it.
	// Idle cycles drop start; the next word replaces an accepted one.
	task automatic send_word(logic [1:0] rq, logic signed [31:0] x,
			logic signed [31:0] y, logic signed [31:0] s);
		if (!calm) begin
			while ($urandom_range(99) < 23) begin
				start <= 1'b0;
				req_type <= 2'($urandom_range(3));
				point_x <= $urandom;
				point_y <= $urandom;
				sample <= $urandom;
				@(posedge clk);
			end
		end
		start <= 1'b1;
		req_type <= rq;
		point_x <= x;
		point_y <= y;
		sample <= s;
		do @(posedge clk); while (busy);
		// accepted at this edge: model it
		sb.note_request(rq, x, y, s);
		n_sent++;
	endtask

	function automatic logic signed [31:0] rand_edge32();
		case ($urandom_range(5))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return 32'sd0;
			3: return $signed($urandom_range(2000)) - 1000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [31:0] rand_q16();
		return ($signed($urandom_range(400)) - 200) <<< 16 | $urandom_range(65535);
	endfunction

	// Clear, build a table of a random size and direction, then evaluate it, with an unused code now and then.
	task automatic run_table();
		int npts, evals;
		bit down;
		logic signed [31:0] x;
		npts = ($urandom_range(9) == 0) ? $urandom_range(60, MAX_PTS + 3)
			: $urandom_range(0, 8);
		down = $urandom_range(1);
		evals = $urandom_range(2, 10);
		x = rand_q16();
		send_word(plc_pkg::REQ_CLEAR, $urandom, $urandom, $urandom);
		for (int i = 0; i < npts; i++) begin
			if ($urandom_range(15) == 0) begin
				send_word(plc_pkg::REQ_APPEND, rand_edge32(), rand_edge32(), $urandom);
			end else begin
				send_word(plc_pkg::REQ_APPEND, x, rand_q16(), $urandom);
				if ($urandom_range(19) != 0)
					x = down ? x - $urandom_range(1, 3 << 16) : x + $urandom_range(1, 3 << 16);
			end
		end
		for (int i = 0; i < evals; i++) begin
			case ($urandom_range(9))
				0: send_word(plc_pkg::REQ_EVAL, $urandom, $urandom, rand_edge32());
				1: send_word(REQ_SPARE, $urandom, $urandom, $urandom);
				default: send_word(plc_pkg::REQ_EVAL, $urandom, $urandom,
					x + (rand_q16() >>> 2));
			endcase
		end
	endtask

	initial begin
		sb = new();
		calm = 0;
		n_sent = 0;
		arst_n = 0;
		start = 0;
		req_type = plc_pkg::REQ_CLEAR;
		point_x = 0;
		point_y = 0;
		sample = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, unused code, extreme points, equal x, full table.
		send_word(plc_pkg::REQ_EVAL, 0, 0, 32'sh7FFF_FFFF);
		send_word(REQ_SPARE, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
		send_word(plc_pkg::REQ_APPEND, 32'sh8000_0000, 32'sh8000_0000, 0);
		send_word(plc_pkg::REQ_EVAL, 0, 0, 0);
		send_word(plc_pkg::REQ_APPEND, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0);
		send_word(plc_pkg::REQ_EVAL, 0, 0, 32'sh8000_0000);
		send_word(plc_pkg::REQ_EVAL, 0, 0, 32'sh7FFF_FFFF);
		send_word(plc_pkg::REQ_APPEND, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
		send_word(plc_pkg::REQ_APPEND, 32'sh0000_0001, 32'sh7FFF_FFFF, 0);
		send_word(plc_pkg::REQ_EVAL, 0, 0, 32'sh0001_0000);
		send_word(plc_pkg::REQ_EVAL, 0, 0, 32'shFFFF_FFFF);
		send_word(plc_pkg::REQ_CLEAR, 0, 0, 0);
		// descending three-point table with a steep first slope
		send_word(plc_pkg::REQ_APPEND, 32'sh0000_0002, 32'sh8000_0000, 0);
		send_word(plc_pkg::REQ_APPEND, 32'sh0000_0001, 32'sh7FFF_FFFF, 0);
		send_word(plc_pkg::REQ_APPEND, 32'sh8000_0000, 32'sd0, 0);
		send_word(plc_pkg::REQ_EVAL, 0, 0, 32'sh8000_0000);
		send_word(plc_pkg::REQ_EVAL, 0, 0, 32'sh0000_0001);
		send_word(plc_pkg::REQ_EVAL, 0, 0, 32'sh7FFF_FFFF);
		send_word(plc_pkg::REQ_CLEAR, 0, 0, 0);
		// fill the table past capacity
		for (int i = 0; i < MAX_PTS + 2; i++)
			send_word(plc_pkg::REQ_APPEND, i <<< 16, $urandom, 0);
		send_word(plc_pkg::REQ_EVAL, 0, 0, 32'sh0020_8000);
		send_word(plc_pkg::REQ_EVAL, 0, 0, 32'sh7FFF_FFFF);

		while (n_sent < 1550) begin
			calm = (n_sent > 600 && n_sent < 850);
			run_table();
		end
		start <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Watchdog for the slowest run: ~1650 words with idle gaps.
	initial begin
		#20ms;
		$display("*** FAILED ***");
		$finish;
	end
endmodule
